[hdl/lmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_pkg: shared types and constants of the line multiset difference unit
// Beat formats, function and result codes, and the key helpers.
// ----------------------------------------------------------------------------
package lmd_pkg;

	localparam int KEY_BYTES       = 40;
	localparam int KEY_W           = KEY_BYTES * 8;
	localparam int LINE_W          = 16;
	localparam int TABLE_DEPTH_DEF = 64;

	localparam logic [LINE_W-1:0] LINE_MAX = '1;

	// function codes of an input beat
	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_PROBE  = 2'd1;
	localparam logic [1:0] FUNC_REPORT = 2'd2;

	// result kinds
	localparam logic [2:0] KIND_LOADED      = 3'd0;
	localparam logic [2:0] KIND_OVERFLOW    = 3'd1;
	localparam logic [2:0] KIND_PROBE_MATCH = 3'd2;
	localparam logic [2:0] KIND_PROBE_UNIQ  = 3'd3;
	localparam logic [2:0] KIND_REF_UNMATCH = 3'd4;
	localparam logic [2:0] KIND_REF_MATCH   = 3'd5;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [KEY_BYTES-1:0] byte_mask_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] key_word_0;
		logic [63:0] key_word_1;
		logic [63:0] key_word_2;
		logic [63:0] key_word_3;
		logic [63:0] key_word_4;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [LINE_W-1:0] line_number;
		logic              last;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_PROBE,
		S_REPORT
	} state_t;

	// Byte positions up to and including the first zero byte of a key;
	// bytes past the string end take no part in the compare.
	function automatic byte_mask_t care_mask(input key_t key);
		logic       seen_zero;
		byte_mask_t mask;
		seen_zero = 1'b0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			mask[i]   = !seen_zero;
			seen_zero = seen_zero | (key[8*i +: 8] == 8'h00);
		end
		return mask;
	endfunction

endpackage

[hdl/lmd_key_cmp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_key_cmp: string compare of a probe key against one stored key
// Bytes are compared in parallel; only bytes under the probe's care mask
// (up to its terminating zero) must agree.
// ----------------------------------------------------------------------------
module lmd_key_cmp (
	input  lmd_pkg::key_t       probe_key,
	input  lmd_pkg::key_t       stored_key,
	input  lmd_pkg::byte_mask_t care,
	output logic                match
);
	import lmd_pkg::*;

	byte_mask_t byte_eq;

	// per-byte equality
	always_comb begin
		for (int i = 0; i < KEY_BYTES; i++) begin
			byte_eq[i] = probe_key[8*i +: 8] == stored_key[8*i +: 8];
		end
	end

	// equal where every cared-for byte agrees
	assign match = &(byte_eq | ~care);

endmodule

[hdl/line_multiset_difference_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_multiset_difference_unit: reference line table with probe matching
// Stores reference line keys in a RAM, claims the first unclaimed equal key
// for each probe line, and reports every reference line on request.
// ----------------------------------------------------------------------------
//  channel | ports                       | handshake
//  --------+-----------------------------+------------------------------------
//  command | start, busy, in_item        | beat taken when start & !busy
//  result  | strobe, result              | one cycle per beat, no back-pressure
//
//  Load: the result passes through the S_LOAD state and the output register.
//  Probe: one stored key read and compared per cycle through the single read
//  port of the key RAM. Report: one result beat per cycle.
//  Reset clears the counters and the matched marks at once; the key RAM needs
//  no clearing. Results leave through an output register and cannot stall.
// ----------------------------------------------------------------------------
module line_multiset_difference_unit #(
	parameter int TABLE_DEPTH = lmd_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  lmd_pkg::in_item_t  in_item,
	output logic               strobe,
	output lmd_pkg::out_item_t result
);
	import lmd_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// control state
	state_t                 state_q, state_d;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       idx_q;
	logic [LINE_W-1:0]      probe_cnt_q;
	logic [TABLE_DEPTH-1:0] marks_q;
	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   strobe_q;

	// payload registers
	key_t       key_q;
	byte_mask_t care_q;
	key_t       rd_data_s1;
	out_item_t  result_q;

	// RAM
	key_t key_mem [TABLE_DEPTH];

	// decoded controls
	logic       accept;
	logic       full;
	logic       key_match;
	logic       probe_hit;
	logic       probe_done;
	logic       report_last;
	logic       report_done;
	logic       rd_en;
	logic       mem_we;
	logic       count_inc;
	logic       mark_set;
	logic       clear_all;
	logic       emit;
	out_item_t  emit_item;

	assign accept = start && !busy;
	assign busy   = state_q != S_IDLE;
	assign full   = count_q == CNT_W'(TABLE_DEPTH);

	// key compare on the registered read data
	lmd_key_cmp u_cmp (
		.probe_key  (key_q),
		.stored_key (rd_data_s1),
		.care       (care_q),
		.match      (key_match)
	);

	// probe walk and report walk conditions
	always_comb begin
		rd_en       = (state_q == S_PROBE) && (idx_q < count_q);
		probe_hit   = vld_s1 && !marks_q[idx_s1] && key_match;
		probe_done  = (count_q == '0) || probe_hit ||
		              (vld_s1 && ((CNT_W'(idx_s1) + CNT_W'(1)) == count_q));
		report_last = (idx_q + CNT_W'(1)) == count_q;
		report_done = (count_q == '0) || report_last;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_item.func)
						FUNC_LOAD:   state_d = S_LOAD;
						FUNC_PROBE:  state_d = S_PROBE;
						FUNC_REPORT: state_d = S_REPORT;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_LOAD:   state_d = S_IDLE;
			S_PROBE:  if (probe_done) state_d = S_IDLE;
			S_REPORT: if (report_done) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		emit      = 1'b0;
		emit_item = '0;
		mem_we    = 1'b0;
		count_inc = 1'b0;
		mark_set  = 1'b0;
		clear_all = 1'b0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_LOAD: begin
				emit           = 1'b1;
				emit_item.last = 1'b1;
				if (full) begin
					emit_item.kind = KIND_OVERFLOW;
				end else begin
					mem_we                = 1'b1;
					count_inc             = 1'b1;
					emit_item.kind        = KIND_LOADED;
					emit_item.line_number = LINE_W'(count_q) + LINE_W'(1);
				end
			end
			S_PROBE: begin
				emit_item.last        = 1'b1;
				emit_item.line_number = probe_cnt_q;
				emit_item.kind        = probe_hit ? KIND_PROBE_MATCH : KIND_PROBE_UNIQ;
				mark_set              = probe_hit;
				emit                  = probe_done;
			end
			S_REPORT: begin
				if (count_q == '0) begin
					clear_all = 1'b1;
				end else begin
					emit                  = 1'b1;
					emit_item.kind        = marks_q[idx_q[IDX_W-1:0]] ?
					                        KIND_REF_MATCH : KIND_REF_UNMATCH;
					emit_item.line_number = LINE_W'(idx_q) + LINE_W'(1);
					emit_item.last        = report_last;
					clear_all             = report_last;
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			probe_cnt_q <= '0;
			marks_q     <= '0;
			vld_s1      <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			vld_s1   <= rd_en && !probe_done;

			// walk index: issue pointer for probes, entry pointer for reports
			if (accept) begin
				idx_q <= '0;
			end else if (rd_en || state_q == S_REPORT) begin
				idx_q <= idx_q + CNT_W'(1);
			end

			if (accept && in_item.func == FUNC_PROBE && probe_cnt_q != LINE_MAX) begin
				probe_cnt_q <= probe_cnt_q + LINE_W'(1);
			end

			if (clear_all) begin
				count_q     <= '0;
				probe_cnt_q <= '0;
				marks_q     <= '0;
			end else if (count_inc) begin
				count_q                      <= count_q + CNT_W'(1);
				marks_q[count_q[IDX_W-1:0]] <= 1'b0;
			end else if (mark_set) begin
				marks_q[idx_s1] <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= {in_item.key_word_4, in_item.key_word_3, in_item.key_word_2,
			           in_item.key_word_1, in_item.key_word_0};
			care_q <= care_mask({in_item.key_word_4, in_item.key_word_3,
			                     in_item.key_word_2, in_item.key_word_1,
			                     in_item.key_word_0});
		end
		if (rd_en) begin
			idx_s1 <= idx_q[IDX_W-1:0];
		end
		if (emit) begin
			result_q <= emit_item;
		end
	end

	// key RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[count_q[IDX_W-1:0]] <= key_q;
		end
		if (rd_en) begin
			rd_data_s1 <= key_mem[idx_q[IDX_W-1:0]];
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

[hdl/lmd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_checker: port-level checks of the line multiset difference unit
// Watches the command and result beats and their timing.
// ----------------------------------------------------------------------------
module lmd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input lmd_pkg::in_item_t  in_item,
	input logic               strobe,
	input lmd_pkg::out_item_t result
);
	import lmd_pkg::*;

	// a valid command makes the unit busy in the cycle after it is taken
	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (in_item.func == FUNC_LOAD || in_item.func == FUNC_PROBE ||
		 in_item.func == FUNC_REPORT)) |=> busy)
		else $error("command accepted without going busy");

	// results come out of the busy phase, one register late
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result beat without a preceding busy cycle");

	// the final beat of an item is never followed straight away by another
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |=> !strobe)
		else $error("result beat directly after a final beat");

	// only report beats may be non-final
	a_nonlast_report: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |->
		(result.kind == KIND_REF_UNMATCH || result.kind == KIND_REF_MATCH))
		else $error("non-final beat that is not a report line");

	// overflow carries no line number
	a_overflow_line: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.kind == KIND_OVERFLOW) |-> (result.line_number == '0))
		else $error("overflow beat with a line number");

endmodule

bind line_multiset_difference_unit lmd_checker u_lmd_checker (.*);

[tb/tb_line_multiset_difference_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_multiset_difference_unit: self-checking bench for the line table
// Drives load, probe and report beats through the command handshake. Each
// accepted beat goes through a line-table tracker of the bench's own, and
// every result beat is compared with the oldest verdict still due. A short
// table of directed beats comes first, then randomised load/probe/report
// sessions with bursty pacing.
// ----------------------------------------------------------------------------
module tb_line_multiset_difference_unit;
	import lmd_pkg::*;

	localparam int         DEPTH       = TABLE_DEPTH_DEF;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int         RAND_ITEMS  = 160;

	typedef struct {
		in_item_t  item;
		int        n_fixed;	// -1: tracker decides, else fixed count
		out_item_t fixed;
	} row_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  in_item;
	logic      strobe;
	out_item_t result;

	// tracked table contents
	key_t        line_keys [DEPTH];
	bit          line_claimed [DEPTH];
	int          line_fill;
	logic [15:0] probe_line;

	out_item_t   due_verdicts [$];
	out_item_t   want;
	int unsigned faults;

	// sender pacing
	int unsigned burst_left;
	bit          steady;

	line_multiset_difference_unit #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.in_item(in_item),
		.strobe (strobe),
		.result (result)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic in_item_t beat(input logic [1:0] f, input key_t k);
		in_item_t it;
		it.func       = f;
		it.key_word_0 = k[63:0];
		it.key_word_1 = k[127:64];
		it.key_word_2 = k[191:128];
		it.key_word_3 = k[255:192];
		it.key_word_4 = k[319:256];
		return it;
	endfunction

	function automatic key_t text_key(input string s);
		key_t k;
		k = '0;
		for (int i = 0; i < s.len() && i < KEY_BYTES; i++)
			k[8*i +: 8] = s[i];
		return k;
	endfunction

	function automatic key_t any_key();
		key_t k;
		for (int i = 0; i < KEY_W / 32; i++)
			k[32*i +: 32] = $urandom;
		return k;
	endfunction

	// mostly short lines over a small alphabet, so that repeats are common
	function automatic key_t random_line();
		key_t        k;
		int unsigned len;
		k   = '0;
		len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, KEY_BYTES) : $urandom_range(0, 6);
		for (int i = 0; i < len; i++)
			k[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
				: 8'($urandom_range(97, 100));
		// bytes past the terminator are ignored by the compare
		if (len < KEY_BYTES - 1 && $urandom_range(0, 4) == 0) begin
			for (int i = len + 1; i < KEY_BYTES; i++)
				k[8*i +: 8] = 8'($urandom);
		end
		return k;
	endfunction

	function automatic in_item_t noise_item();
		return beat(2'($urandom_range(0, 3)), any_key());
	endfunction

	// string equality over at most 40 bytes, stopping at a shared zero byte
	function automatic bit lines_equal(input key_t a, input key_t b);
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (a[8*i +: 8] != b[8*i +: 8])
				return 1'b0;
			if (a[8*i +: 8] == 8'h00)
				return 1'b1;
		end
		return 1'b1;
	endfunction

	// Apply one accepted beat to the tracked table; queue its verdicts if keep
	function automatic void line_verdicts(input in_item_t item, input bit keep);
		key_t      k;
		out_item_t r;
		bit        hit;
		k      = {item.key_word_4, item.key_word_3, item.key_word_2,
			item.key_word_1, item.key_word_0};
		r.last = 1'b1;
		hit    = 1'b0;
		case (item.func)
			FUNC_LOAD: begin
				if (line_fill >= DEPTH) begin
					r.kind        = KIND_OVERFLOW;
					r.line_number = '0;
				end else begin
					line_keys[line_fill]    = k;
					line_claimed[line_fill] = 1'b0;
					line_fill++;
					r.kind        = KIND_LOADED;
					r.line_number = 16'(line_fill);
				end
				if (keep)
					due_verdicts.push_back(r);
			end
			FUNC_PROBE: begin
				if (probe_line != LINE_MAX)
					probe_line++;
				for (int j = 0; j < line_fill && !hit; j++) begin
					if (!line_claimed[j] && lines_equal(k, line_keys[j])) begin
						line_claimed[j] = 1'b1;
						hit             = 1'b1;
					end
				end
				r.kind        = hit ? KIND_PROBE_MATCH : KIND_PROBE_UNIQ;
				r.line_number = probe_line;
				if (keep)
					due_verdicts.push_back(r);
			end
			FUNC_REPORT: begin
				for (int j = 0; j < line_fill; j++) begin
					r.kind        = line_claimed[j] ? KIND_REF_MATCH : KIND_REF_UNMATCH;
					r.line_number = 16'(j + 1);
					r.last        = (j + 1 == line_fill);
					if (keep)
						due_verdicts.push_back(r);
					line_claimed[j] = 1'b0;
				end
				line_fill  = 0;
				probe_line = '0;
			end
			default: ;
		endcase
	endfunction

	// hold the beat until a clock edge sees start high and busy low
	task automatic offer(input in_item_t item);
		start   <= 1'b1;
		in_item <= item;
		do
			@(posedge clk);
		while (busy);
	endtask

	// bursts of beats with random gaps; junk on the bus while start is low
	task automatic pace();
		int unsigned gap;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			steady     = ($urandom_range(0, 5) == 0);
			burst_left = steady ? $urandom_range(8, 30) : $urandom_range(0, 12);
			gap        = steady ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				start   <= 1'b0;
				in_item <= noise_item();
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic issue(input in_item_t item);
		offer(item);
		line_verdicts(item, 1'b1);
		pace();
	endtask

	// sender holds off until every due verdict is in
	task automatic settle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (due_verdicts.size() != 0);
	endtask

	function automatic row_t row(input logic [1:0] f, input key_t k, input int n,
		input logic [2:0] kind, input int line, input bit last);
		row_t r;
		r.item              = beat(f, k);
		r.n_fixed           = n;
		r.fixed.kind        = kind;
		r.fixed.line_number = 16'(line);
		r.fixed.last        = last;
		return r;
	endfunction

	// result checker: no back-pressure, so every strobe is a result beat
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (due_verdicts.size() == 0) begin
				$error("result beat with none due: kind %0d line_number %0d last %0d",
					result.kind, result.line_number, result.last);
				faults++;
			end else begin
				want = due_verdicts.pop_front();
				if (result.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, result.kind);
					faults++;
				end
				if (result.line_number !== want.line_number) begin
					$error("line_number: expected %0d, got %0d",
						want.line_number, result.line_number);
					faults++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result.last);
					faults++;
				end
			end
		end
	end

	// run limit
	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		row_t        plan [$];
		key_t        pool [$];
		key_t        k;
		in_item_t    it;
		int unsigned random_items;
		int unsigned loads;
		int unsigned probes;
		int unsigned pick;
		int          len;
		int          idx;
		bit          first_session;

		faults        = 0;
		line_fill     = 0;
		probe_line    = '0;
		burst_left    = 0;
		steady        = 1'b0;
		random_items  = 0;
		first_session = 1'b1;
		for (int j = 0; j < DEPTH; j++)
			line_claimed[j] = 1'b0;

		arst_n  <= 1'b0;
		start   <= 1'b0;
		in_item <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats
		plan.push_back(row(FUNC_REPORT, '0, 0, KIND_LOADED, 0, 1'b0));	// empty report
		plan.push_back(row(FUNC_UNUSED, '1, 0, KIND_LOADED, 0, 1'b0));
		plan.push_back(row(FUNC_LOAD, '0, 1, KIND_LOADED, 1, 1'b1));		// empty line
		plan.push_back(row(FUNC_LOAD, '1, 1, KIND_LOADED, 2, 1'b1));		// no terminator
		plan.push_back(row(FUNC_LOAD, text_key("abc"), 1, KIND_LOADED, 3, 1'b1));
		plan.push_back(row(FUNC_LOAD, text_key("abc") | {{36{8'hA5}}, 32'h0}, 1,
			KIND_LOADED, 4, 1'b1));						// junk past the end
		plan.push_back(row(FUNC_LOAD, text_key("abd"), 1, KIND_LOADED, 5, 1'b1));
		plan.push_back(row(FUNC_PROBE, text_key("abc"), -1, KIND_LOADED, 0, 1'b0));
		plan.push_back(row(FUNC_PROBE, text_key("abc"), -1, KIND_LOADED, 0, 1'b0));
		plan.push_back(row(FUNC_PROBE, text_key("abc"), -1, KIND_LOADED, 0, 1'b0));
		plan.push_back(row(FUNC_PROBE, '1, -1, KIND_LOADED, 0, 1'b0));
		plan.push_back(row(FUNC_PROBE, {8'hFE, {39{8'hFF}}}, -1, KIND_LOADED, 0, 1'b0));
		plan.push_back(row(FUNC_PROBE, {{39{8'hFF}}, 8'h00}, -1, KIND_LOADED, 0, 1'b0));
		plan.push_back(row(FUNC_UNUSED, text_key("abd"), 0, KIND_LOADED, 0, 1'b0));
		plan.push_back(row(FUNC_REPORT, '1, -1, KIND_LOADED, 0, 1'b0));
		plan.push_back(row(FUNC_PROBE, text_key("x"), 1, KIND_PROBE_UNIQ, 1, 1'b1));
		plan.push_back(row(FUNC_REPORT, '0, 0, KIND_LOADED, 0, 1'b0));	// cleared again
		plan.push_back(row(FUNC_LOAD, {40{8'h01}}, 1, KIND_LOADED, 1, 1'b1));
		plan.push_back(row(FUNC_REPORT, '0, 1, KIND_REF_UNMATCH, 1, 1'b1));

		foreach (plan[r]) begin
			offer(plan[r].item);
			line_verdicts(plan[r].item, plan[r].n_fixed < 0);
			if (plan[r].n_fixed == 1)
				due_verdicts.push_back(plan[r].fixed);
			pace();
		end

		// random sessions: loads, probes mostly drawn from the loaded lines, report
		while (random_items < RAND_ITEMS) begin
			loads = first_session ? DEPTH + $urandom_range(1, 3)
				: (($urandom_range(0, 7) == 0) ? $urandom_range(20, DEPTH) : $urandom_range(1, 10));
			for (int n = 0; n < loads; n++) begin
				k = random_line();
				pool.push_back(k);
				issue(beat(FUNC_LOAD, k));
				random_items++;
				if ($urandom_range(0, 9) == 0) begin
					it = noise_item();
					issue(it);
					if (it.func != FUNC_UNUSED)
						random_items++;
				end
			end

			probes = $urandom_range(1, loads + 3);
			for (int n = 0; n < probes; n++) begin
				k   = (pool.size() != 0) ? pool[$urandom_range(0, pool.size() - 1)] : random_line();
				len = KEY_BYTES;
				for (int i = KEY_BYTES - 1; i >= 0; i--)
					if (k[8*i +: 8] == 8'h00)
						len = i;
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					// same line, fresh bytes past its end
					for (int i = len + 1; i < KEY_BYTES; i++)
						k[8*i +: 8] = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom);
				end else if (pick < 8 && len != 0) begin
					idx             = $urandom_range(0, len - 1);
					k[8*idx +: 8]   = k[8*idx +: 8] ^ 8'($urandom_range(1, 255));
				end else begin
					k = ($urandom_range(0, 1) != 0) ? random_line() : any_key();
				end
				issue(beat(FUNC_PROBE, k));
				random_items++;
			end

			if (first_session || $urandom_range(0, 4) == 0)
				settle();
			if (first_session || $urandom_range(0, 5) != 0) begin
				issue(beat(FUNC_REPORT, any_key()));
				random_items++;
				pool.delete();
			end
			first_session = 1'b0;
		end

		// drain: wait for every due verdict, then a report's worth of quiet
		start <= 1'b0;
		for (int w = 0; w < 20000 && due_verdicts.size() != 0; w++)
			@(posedge clk);
		repeat (DEPTH + 16) @(posedge clk);
		if (due_verdicts.size() != 0) begin
			$error("%0d result beats never arrived", due_verdicts.size());
			faults++;
		end

		if (faults == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
